### src/assert_macros.svh
// Assertion macros used by the RAID5 parity encoder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ON(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_ON(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

### src/r5pc_pkg.sv
// Types, codes and the CRC32C step shared by the RAID5 parity encoder
`default_nettype none

package r5pc_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_PARITY     = 2'd0;
  localparam kind_t KIND_DATA_CRC   = 2'd1;
  localparam kind_t KIND_PARITY_CRC = 2'd2;

  localparam logic [1:0] REG_NUM_STRIPS  = 2'd0;
  localparam logic [1:0] REG_STRIP_WORDS = 2'd1;
  localparam logic [1:0] REG_CRC_ENABLE  = 2'd2;

  localparam logic [3:0] RST_NUM_STRIPS  = 4'd2;
  localparam logic [9:0] RST_STRIP_WORDS = 10'd512;
  localparam logic       RST_CRC_ENABLE  = 1'b1;

  localparam int          MIN_STRIP_WORDS = 8;
  localparam logic [3:0]  MIN_DATA_STRIPS = 4'd2;

  localparam logic [31:0] CRC32C_POLY = 32'h82F63B78;
  localparam int          CRC_IN_W    = 96;

  typedef logic [CRC_IN_W-1:0][31:0] crc_cols_t;

  // Response of one 64-bit reflected step to each single input bit
  function automatic crc_cols_t crc_cols();
    crc_cols_t   cols;
    logic [31:0] c;
    logic [63:0] d;
    logic        fb;
    for (int j = 0; j < CRC_IN_W; j++) begin
      c = (j < 32) ? (32'd1 << j) : 32'd0;
      d = (j < 32) ? 64'd0 : (64'd1 << (j - 32));
      for (int i = 0; i < 64; i++) begin
        fb = c[0] ^ d[i];
        c  = c >> 1;
        if (fb) begin
          c = c ^ CRC32C_POLY;
        end
      end
      cols[j] = c;
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = crc_cols();

  // One 64-bit CRC32C step as an XOR tree over the column masks
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [63:0] data);
    logic [31:0] acc;
    acc = 32'd0;
    for (int j = 0; j < 32; j++) begin
      if (crc[j]) begin
        acc = acc ^ CRC_COLS[j];
      end
    end
    for (int j = 0; j < 64; j++) begin
      if (data[j]) begin
        acc = acc ^ CRC_COLS[32 + j];
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

### src/r5pc_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module r5pc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/raid5_parity_encode_crc32c.sv
// RAID5 parity encoder with per-strip CRC32C, top level
//
// Usage: program num_data_strips, strip_words and crc_enable over the APB
// port (byte addresses 0, 4, 8) while idle; any register write restarts the
// encode. Then feed data strips word by word: a word transfers when start is
// high and busy is low; crc_seed is taken on the first word of each strip,
// parity_crc_seed on the first word of the last strip.
// Results leave on kind, strip_number, value and last, one per cycle, each
// marked by strobe for exactly one cycle; the receiver cannot stall them.
// Order per word: parity word, data strip CRC, parity strip CRC.
// Flow: the parity store is a RAM with a registered read, so a word passes
// through the read and then the read-modify-write; its results then leave
// one at a time on the single result port. busy stays high, and no new word
// transfers, until the last result of the word is on the port.
// Reset clears positions, CRCs and registers to their defaults; the parity
// store is not cleared, as each entry is written before it is read.
`default_nettype none
`include "assert_macros.svh"

module raid5_parity_encode_crc32c #(
  parameter int MAX_STRIP_WORDS = 512,
  parameter int MAX_DATA_STRIPS = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [63:0]           data_word,
  input  wire logic [31:0]           crc_seed,
  input  wire logic [31:0]           parity_crc_seed,
  output logic                       strobe,
  output r5pc_pkg::kind_t            kind,
  output logic      [3:0]            strip_number,
  output logic      [63:0]           value,
  output logic                       last
);

  import r5pc_pkg::*;

  localparam int AW = $clog2(MAX_STRIP_WORDS);
  localparam int CW = $clog2(MAX_STRIP_WORDS + 1);
  localparam int LW = (CW > 10) ? CW : 10;

  localparam logic [LW-1:0] MAX_WORDS_L = LW'(MAX_STRIP_WORDS);
  localparam logic [LW-1:0] MIN_WORDS_L = LW'(MIN_STRIP_WORDS);
  localparam logic [3:0]    MAX_STRIPS  = 4'(MAX_DATA_STRIPS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state;
  logic [3:0]    num_data_strips;
  logic [9:0]    strip_words;
  logic          crc_enable;
  logic [31:0]   data_crc;
  logic [31:0]   parity_crc;
  logic [AW-1:0] word_position;
  logic [3:0]    strip_position;

  logic [AW-1:0] w_q;
  logic [3:0]    s_q;
  logic [3:0]    strips_q;
  logic          last_strip_q;
  logic          strip_end_q;
  logic [63:0]   data_q;
  logic [31:0]   seed_q;
  logic [31:0]   pseed_q;
  logic [63:0]   parity_q;
  logic [2:0]    pend;

  logic          cfg_write;
  logic          accept;
  logic [3:0]    strips_eff;
  logic [LW-1:0] words_l;
  logic [CW-1:0] words_m1;
  logic [AW-1:0] w_cur;
  logic [3:0]    s_cur;
  logic          last_strip;
  logic          strip_end;
  logic [63:0]   rdata;
  logic [63:0]   parity_next;
  logic [31:0]   dcrc_base;
  logic [31:0]   pcrc_base;
  logic [2:0]    pend_next;
  logic [2:0]    pend_left;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  always_comb begin
    case (paddr[3:2])
      REG_NUM_STRIPS:  prdata = {28'd0, num_data_strips};
      REG_STRIP_WORDS: prdata = {22'd0, strip_words};
      REG_CRC_ENABLE:  prdata = {31'd0, crc_enable};
      default:         prdata = 32'd0;
    endcase
  end

  always_comb begin
    strips_eff = num_data_strips;
    if (strips_eff < MIN_DATA_STRIPS) begin
      strips_eff = MIN_DATA_STRIPS;
    end
    if (strips_eff > MAX_STRIPS) begin
      strips_eff = MAX_STRIPS;
    end
    words_l = LW'(strip_words);
    if (words_l < MIN_WORDS_L) begin
      words_l = MIN_WORDS_L;
    end
    if (words_l > MAX_WORDS_L) begin
      words_l = MAX_WORDS_L;
    end
    words_l  = words_l & ~LW'(7);
    words_m1 = CW'(words_l - LW'(1));
    w_cur    = (CW'(word_position) > words_m1) ? '0 : word_position;
    s_cur    = (strip_position >= strips_eff) ? 4'd0 : strip_position;
    last_strip = (s_cur == strips_eff - 4'd1);
    strip_end  = (CW'(w_cur) == words_m1);
  end

  r5pc_ram #(
    .WIDTH(64),
    .DEPTH(MAX_STRIP_WORDS)
  ) u_parity_store (
    .clk  (clk),
    .we   (state == ST_EXEC),
    .waddr(w_q),
    .wdata(parity_next),
    .re   (accept),
    .raddr(w_cur),
    .rdata(rdata)
  );

  always_comb begin
    parity_next = (s_q == 4'd0) ? data_q : (rdata ^ data_q);
    dcrc_base   = (w_q == '0) ? seed_q : data_crc;
    pcrc_base   = ((w_q == '0) && last_strip_q) ? pseed_q : parity_crc;
    pend_next   = {crc_enable && strip_end_q && last_strip_q,
                   crc_enable && strip_end_q,
                   last_strip_q};
    pend_left   = pend & (pend - 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      num_data_strips <= RST_NUM_STRIPS;
      strip_words     <= RST_STRIP_WORDS;
      crc_enable      <= RST_CRC_ENABLE;
      data_crc        <= 32'd0;
      parity_crc      <= 32'd0;
      word_position   <= '0;
      strip_position  <= 4'd0;
      pend            <= 3'd0;
      strobe          <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_write && (paddr[3:2] != 2'd3)) begin
        case (paddr[3:2])
          REG_NUM_STRIPS:  num_data_strips <= pwdata[3:0];
          REG_STRIP_WORDS: strip_words     <= pwdata[9:0];
          REG_CRC_ENABLE:  crc_enable      <= pwdata[0];
          default:         num_data_strips <= num_data_strips;
        endcase
        data_crc       <= 32'd0;
        parity_crc     <= 32'd0;
        word_position  <= '0;
        strip_position <= 4'd0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
            if (strip_end) begin
              word_position  <= '0;
              strip_position <= last_strip ? 4'd0 : s_cur + 4'd1;
            end else begin
              word_position  <= w_cur + AW'(1);
              strip_position <= s_cur;
            end
          end
        end
        ST_EXEC: begin
          data_crc <= crc_enable ? crc_step(dcrc_base, data_q) : dcrc_base;
          parity_crc <= (crc_enable && last_strip_q) ? crc_step(pcrc_base, parity_next)
                                                     : pcrc_base;
          pend  <= pend_next;
          state <= (pend_next != 3'd0) ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          strobe <= 1'b1;
          pend   <= pend_left;
          if (pend_left == 3'd0) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w_q          <= w_cur;
      s_q          <= s_cur;
      strips_q     <= strips_eff;
      last_strip_q <= last_strip;
      strip_end_q  <= strip_end;
      data_q       <= data_word;
      seed_q       <= crc_seed;
      pseed_q      <= parity_crc_seed;
    end
    if (state == ST_EXEC) begin
      parity_q <= parity_next;
    end
    if (state == ST_EMIT) begin
      if (pend[0]) begin
        kind         <= KIND_PARITY;
        strip_number <= strips_q;
        value        <= parity_q;
        last         <= !crc_enable && strip_end_q;
      end else if (pend[1]) begin
        kind         <= KIND_DATA_CRC;
        strip_number <= s_q;
        value        <= {32'd0, data_crc};
        last         <= 1'b0;
      end else begin
        kind         <= KIND_PARITY_CRC;
        strip_number <= strips_q;
        value        <= {32'd0, parity_crc};
        last         <= 1'b1;
      end
    end
  end

  `ASSERT_ON(a_exec_after_transfer, clk, rst, (state == ST_EXEC) |-> $past(start && !busy), "read-modify-write without a transfer")
  `ASSERT_NEVER(a_kind_valid, clk, rst, strobe && (kind == 2'd3), "result kind out of range")
  `ASSERT_ON(a_last_is_final, clk, rst, (strobe && last) |=> !strobe, "result after the final result")
  `ASSERT_NEVER(a_parity_last_crc, clk, rst, strobe && last && (kind == KIND_PARITY) && crc_enable, "parity word marked final with CRC on")
  `ASSERT_ON(a_emit_pending, clk, rst, (state == ST_EMIT) |-> (pend != 3'd0), "emit state with nothing pending")

endmodule

`default_nettype wire
